// ===== src/random_cycle_pointer_chase_defines.svh =====
// Assertion macros for the pointer chase block.
`ifndef RANDOM_CYCLE_POINTER_CHASE_DEFINES_SVH
`define RANDOM_CYCLE_POINTER_CHASE_DEFINES_SVH
`ifndef SYNTH
`define RCPC_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("label");
`define RCPC_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("label");
`define RCPC_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("label");
`else
`define RCPC_ASSERT(label, cond)
`define RCPC_IMPLY(label, ante, cons)
`define RCPC_NEXT(label, ante, cons)
`endif
`endif

// ===== src/rcpc_pkg.sv =====
// Package: constants, types and the xorshift step for the pointer chase.
package rcpc_pkg;
  localparam int MAX_NODES  = 4096;
  localparam int INDEX_BITS = 12;
  localparam int COUNT_BITS = INDEX_BITS + 1;
  localparam int WORD_BITS  = 32;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [WORD_BITS-1:0]  word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILL, ST_DRAW, ST_MOD, ST_RD, ST_RDW, ST_WR,
    ST_LINK, ST_LINKW, ST_STEPS, ST_WALK, ST_WALKW, ST_DONE
  } state_t;

  // divider control / status
  typedef struct packed {
    logic  start;
    word_t dividend;
    cnt_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    cnt_t  rem;
  } div_rsp_t;

  function automatic word_t xs32(input word_t x);
    word_t a, b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction
endpackage

// ===== src/random_cycle_pointer_chase.sv =====
// Top level: random cyclic permutation builder and pointer chaser.
// The walk takes access_count mod n steps for n >= 2 nodes; a node count below two
//   skips the build and the walk. One item at a time.
// The per-swap cost is set by the bit-serial remainder unit;
//   the walk reads the successor store once a step.
// Reset (rst_n low, synchronous) idles the sequencer and clears the generator;
//   the stores are not cleared. Results are strobed for one cycle; the receiver cannot stall.
module random_cycle_pointer_chase import rcpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_seed,
  input  logic [12:0] in_node_count,
  input  logic [31:0] in_access_count,
  output logic        out_valid,
  output logic [11:0] out_final_index,
  output logic        out_status
);
  div_req_t dreq;
  div_rsp_t drsp;
  logic     o_we, s_we;
  idx_t     o_waddr, o_wdata, o_raddr, o_rdata;
  idx_t     s_waddr, s_wdata, s_raddr, s_rdata;

  // bit-serial remainder for swap partners and the walk length
  rcpc_mod u_mod (.clk, .rst_n, .req(dreq), .rsp(drsp));

  // order store: shuffled permutation
  rcpc_ram #(.DEPTH(MAX_NODES), .WIDTH(INDEX_BITS)) u_order (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata)
  );

  // successor store: the linked cycle
  rcpc_ram #(.DEPTH(MAX_NODES), .WIDTH(INDEX_BITS)) u_succ (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  rcpc_ctrl u_ctrl (
    .clk, .rst_n, .start, .seed(in_seed), .node_count(in_node_count),
    .access_count(in_access_count), .busy, .done(out_valid),
    .final_index(out_final_index), .status(out_status), .dreq, .drsp,
    .o_we, .o_waddr, .o_wdata, .o_raddr, .o_rdata,
    .s_we, .s_waddr, .s_wdata, .s_raddr, .s_rdata
  );
endmodule

// ===== src/rcpc_ram.sv =====
// Generic single-port-write, single-read synchronous RAM.
module rcpc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/rcpc_mod.sv =====
// Restoring remainder unit: 32-bit dividend mod 13-bit divisor, one bit a cycle.
module rcpc_mod import rcpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int SH_BITS = $clog2(WORD_BITS);
  cnt_t                rem_r, rem_nxt;
  word_t               dvd_r, dvd_nxt;
  cnt_t                dvs_r, dvs_nxt;
  logic [SH_BITS-1:0]  bit_r, bit_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [COUNT_BITS:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[WORD_BITS-1]};
    if (req.start && !busy_r) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      bit_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[WORD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = cnt_t'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = cnt_t'(trial);
      end
      bit_nxt = bit_r + 1'b1;
      if (bit_r == SH_BITS'(WORD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    bit_r <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
endmodule

// ===== src/rcpc_ctrl.sv =====
// Sequencer: fill, shuffle, link and walk over the two stores.
module rcpc_ctrl import rcpc_pkg::*;
`include "random_cycle_pointer_chase_defines.svh"
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  word_t    seed,
  input  cnt_t     node_count,
  input  word_t    access_count,
  output logic     busy,
  output logic     done,
  output idx_t     final_index,
  output logic     status,
  output div_req_t dreq,
  input  div_rsp_t drsp,
  output logic     o_we,
  output idx_t     o_waddr,
  output idx_t     o_wdata,
  output idx_t     o_raddr,
  input  idx_t     o_rdata,
  output logic     s_we,
  output idx_t     s_waddr,
  output idx_t     s_wdata,
  output idx_t     s_raddr,
  input  idx_t     s_rdata
);
  state_t state_r, state_nxt;
  cnt_t   n_r, n_nxt;
  cnt_t   i_r, i_nxt;
  idx_t   j_r, j_nxt;
  idx_t   a_r, a_nxt;     // order[i] during a swap, order[0] during linking
  idx_t   prev_r, prev_nxt;
  word_t  rng_r, rng_nxt;
  word_t  acc_r, acc_nxt;
  cnt_t   steps_r, steps_nxt;
  idx_t   idx_r, idx_nxt;
  logic   sts_r, sts_nxt;
  logic   phase_r, phase_nxt;
  word_t  draw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rng_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rng_r   <= rng_nxt;
    end
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    a_r     <= a_nxt;
    prev_r  <= prev_nxt;
    acc_r   <= acc_nxt;
    steps_r <= steps_nxt;
    idx_r   <= idx_nxt;
    sts_r   <= sts_nxt;
    phase_r <= phase_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; i_nxt = i_r; j_nxt = j_r; a_nxt = a_r; prev_nxt = prev_r;
    rng_nxt = rng_r; acc_nxt = acc_r; steps_nxt = steps_r; idx_nxt = idx_r;
    sts_nxt = sts_r; phase_nxt = phase_r;
    draw = xs32(rng_r);
    dreq = '{start: 1'b0, dividend: '0, divisor: '0};
    o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          acc_nxt = access_count;
          if (node_count < cnt_t'(2)) begin
            sts_nxt = 1'b1;
            idx_nxt = '0;
            state_nxt = ST_DONE;
          end else begin
            sts_nxt = 1'b0;
            n_nxt = (node_count > cnt_t'(MAX_NODES)) ? cnt_t'(MAX_NODES) : node_count;
            rng_nxt = seed;
            i_nxt = '0;
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        o_we = 1'b1;
        o_waddr = i_r[INDEX_BITS-1:0];
        o_wdata = i_r[INDEX_BITS-1:0];
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == n_r) begin
          i_nxt = n_r - 1'b1;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        rng_nxt = draw;
        dreq = '{start: 1'b1, dividend: draw, divisor: i_r + 1'b1};
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (drsp.done) begin
          j_nxt = drsp.rem[INDEX_BITS-1:0];
          o_raddr = i_r[INDEX_BITS-1:0];
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // order[i] lands now; order[j] is requested
        a_nxt = o_rdata;
        o_raddr = j_r;
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        o_we = 1'b1;
        o_waddr = i_r[INDEX_BITS-1:0];
        o_wdata = o_rdata;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        o_we = 1'b1;
        o_waddr = j_r;
        o_wdata = a_r;
        if (i_r == cnt_t'(1)) begin
          i_nxt = '0;
          phase_nxt = 1'b0;
          o_raddr = '0;
          state_nxt = ST_LINK;
        end else begin
          i_nxt = i_r - 1'b1;
          state_nxt = ST_DRAW;
        end
      end
      ST_LINK: begin
        // read order[i]; the write to order[j] above settles before this read
        o_raddr = i_r[INDEX_BITS-1:0];
        state_nxt = ST_LINKW;
      end
      ST_LINKW: begin
        if (i_r == '0) begin
          a_nxt = o_rdata;
        end else begin
          s_we = 1'b1;
          s_waddr = prev_r;
          s_wdata = o_rdata;
        end
        prev_nxt = o_rdata;
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == n_r) begin
          state_nxt = ST_STEPS;
        end else begin
          state_nxt = ST_LINK;
        end
      end
      ST_STEPS: begin
        if (!phase_r) begin
          s_we = 1'b1;
          s_waddr = prev_r;
          s_wdata = a_r;
          dreq = '{start: 1'b1, dividend: acc_r, divisor: n_r};
          phase_nxt = 1'b1;
        end else if (drsp.done) begin
          steps_nxt = drsp.rem;
          idx_nxt = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (steps_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          s_raddr = idx_r;
          state_nxt = ST_WALKW;
        end
      end
      ST_WALKW: begin
        idx_nxt = s_rdata;
        steps_nxt = steps_r - 1'b1;
        state_nxt = ST_WALK;
      end
      ST_DONE: begin
        done = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy        = (state_r != ST_IDLE);
  assign final_index = idx_r;
  assign status      = sts_r;

  `RCPC_IMPLY(a_done_idle_next, done, state_nxt == ST_IDLE)
  `RCPC_IMPLY(a_err_zero, done && status, final_index == '0)
  `RCPC_IMPLY(a_fill_bound, o_we && state_r == ST_FILL, i_r < n_r)
  `RCPC_NEXT(a_start_leaves_idle, start && !busy, busy)
endmodule
